// ----- sv/doqbd_pkg.sv -----
// ----------------------------------------------------------------------------
// doqbd_pkg
// Shared widths, codes and controller/datapath interface types for the
// drop-oldest queue with burst drain.
// ----------------------------------------------------------------------------
package doqbd_pkg;

    localparam int VAL_W      = 32;
    localparam int DCNT_W     = 7;
    localparam int CAP_W      = 11;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic             REQ_ENQ      = 1'b0;
    localparam logic             REQ_DRAIN    = 1'b1;
    localparam logic             REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET    = 11'd1024;

    // controller -> datapath
    typedef struct packed {
        logic enq;      // write the input value into the ring
        logic load;     // latch the drain length
        logic issue;    // read the oldest entry and pop it
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_drain;   // beat at the input is a drain request
        logic n_zero;     // drain would emit nothing
        logic slot_free;  // output buffer can take one more read
        logic left_one;   // this issue is the final one of the drain
    } t_stat;

endpackage

// ----- sv/doqbd_ram.sv -----
// ----------------------------------------------------------------------------
// doqbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module doqbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/doqbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// doqbd_ctrl
// Request sequencer: takes enqueue and drain beats, then steps a drain one
// read per cycle as the output buffer allows.
// ----------------------------------------------------------------------------
module doqbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  doqbd_pkg::t_stat i_stat,
    output doqbd_pkg::t_cmd  o_cmd
);
    import doqbd_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_stat.is_drain) begin
                        o_cmd.enq = 1'b1;
                    end else if (!i_stat.n_zero) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_stat.slot_free) begin
                    o_cmd.issue = 1'b1;
                    if (i_stat.left_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/doqbd_dp.sv -----
// ----------------------------------------------------------------------------
// doqbd_dp
// Ring pointers, occupancy, drop-oldest rule, drain length, the store RAM
// and a two-entry output buffer that keeps reads flowing under backpressure.
// ----------------------------------------------------------------------------
module doqbd_dp #(
    parameter int DEPTH     = 1024,
    parameter int MAX_DRAIN = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [doqbd_pkg::CAP_W-1:0]         i_capacity,
    input  logic                                i_req_type,
    input  logic signed [doqbd_pkg::VAL_W-1:0]  i_value,
    input  logic [doqbd_pkg::DCNT_W-1:0]        i_drain_count,
    input  doqbd_pkg::t_cmd                     i_cmd,
    output doqbd_pkg::t_stat                    o_stat,
    output logic                                o_m_valid,
    input  logic                                i_m_ready,
    output logic signed [doqbd_pkg::VAL_W-1:0]  o_m_value,
    output logic                                o_m_last
);
    import doqbd_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int LEFT_W = $clog2(MAX_DRAIN + 1);
    localparam int CW     = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int NW     = (OCC_W > DCNT_W) ? OCC_W : DCNT_W;

    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [OCC_W-1:0]  r_occ;
    logic [LEFT_W-1:0] r_left;
    logic              r_pend;
    logic              r_pend_last;
    logic [1:0]        r_q_cnt;
    logic [VAL_W-1:0]  r_q_data [2];
    logic              r_q_last [2];

    logic [CW-1:0]     cap_ext;
    logic [CW-1:0]     eff_cap;
    logic              full;
    logic [DCNT_W-1:0] cnt_sat;
    logic [NW-1:0]     cnt_ext;
    logic [NW-1:0]     occ_ext;
    logic [NW-1:0]     n_len;
    logic [VAL_W-1:0]  rd_data;
    logic              pop;
    logic [1:0]        used;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [PTR_W-1:0]  wr_ptr_inc;

    // capacity zero acts as one, above the ring it saturates
    always_comb begin
        cap_ext = CW'(i_capacity);
        if (cap_ext == '0) begin
            eff_cap = CW'(1);
        end else if (cap_ext > CW'(DEPTH)) begin
            eff_cap = CW'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
        full = (CW'(r_occ) >= eff_cap);
    end

    always_comb begin
        cnt_sat = (i_drain_count > DCNT_W'(MAX_DRAIN)) ? DCNT_W'(MAX_DRAIN) : i_drain_count;
        cnt_ext = NW'(cnt_sat);
        occ_ext = NW'(r_occ);
        n_len   = (cnt_ext < occ_ext) ? cnt_ext : occ_ext;
    end

    assign rd_ptr_inc = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign wr_ptr_inc = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;

    assign o_m_valid = (r_q_cnt != 2'd0);
    assign pop       = o_m_valid && i_m_ready;
    // occupied plus in-flight slots once this cycle's pop is gone
    assign used      = r_q_cnt + {1'b0, r_pend} - {1'b0, pop};

    always_comb begin
        o_stat.is_drain  = (i_req_type == REQ_DRAIN);
        o_stat.n_zero    = (n_len == '0);
        o_stat.slot_free = (used < 2'd2);
        o_stat.left_one  = (r_left == LEFT_W'(1));
    end

    assign o_m_value = r_q_data[0];
    assign o_m_last  = r_q_last[0];

    doqbd_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_value),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_ptr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_occ    <= '0;
            r_left   <= '0;
            r_pend   <= 1'b0;
            r_q_cnt  <= 2'd0;
        end else begin
            r_pend <= i_cmd.issue;
            if (i_cmd.enq) begin
                r_wr_ptr <= wr_ptr_inc;
                // drop the oldest when full, so occupancy holds
                if (full) begin
                    r_rd_ptr <= rd_ptr_inc;
                end else begin
                    r_occ <= r_occ + 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_left <= LEFT_W'(n_len);
            end
            if (i_cmd.issue) begin
                r_rd_ptr <= rd_ptr_inc;
                r_occ    <= r_occ - 1'b1;
                r_left   <= r_left - 1'b1;
            end
            r_q_cnt <= r_q_cnt + {1'b0, r_pend} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_pend_last <= (r_left == LEFT_W'(1));
        end
        if (pop) begin
            if (r_pend && r_q_cnt == 2'd1) begin
                r_q_data[0] <= rd_data;
                r_q_last[0] <= r_pend_last;
            end else begin
                r_q_data[0] <= r_q_data[1];
                r_q_last[0] <= r_q_last[1];
            end
        end else if (r_pend && r_q_cnt == 2'd0) begin
            r_q_data[0] <= rd_data;
            r_q_last[0] <= r_pend_last;
        end
        if (r_pend && ((r_q_cnt == 2'd1 && !pop) || (r_q_cnt == 2'd2 && pop))) begin
            r_q_data[1] <= rd_data;
            r_q_last[1] <= r_pend_last;
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_occ) <= CW'(DEPTH))
        else $error("occupancy above ring depth");

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= 2'd2)
        else $error("output buffer overflow");

    a_issue_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (r_occ != '0 && r_left != '0))
        else $error("read issued with nothing left to drain");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_q_cnt < 2'd2 || pop))
        else $error("read data arrived with no buffer room");

endmodule

// ----- sv/drop_oldest_queue_burst_drain.sv -----
// ----------------------------------------------------------------------------
// drop_oldest_queue_burst_drain
// Bounded queue with drop-oldest overflow and burst drain, stream ports and
// an APB capacity register.
// ----------------------------------------------------------------------------
// An enqueue beat (tuser 0) is taken every cycle outside a drain; once the
// queue holds capacity values the oldest is dropped as the new one is
// stored. A drain beat (tuser 1) emits up to drain_count (at most MAX_DRAIN)
// of the oldest values, tlast on the final one; an empty queue or zero count
// emits nothing. A drain holds s_axis_tready low after its beat until its
// last value is read from the single read port of the store RAM, one value
// read per cycle while m_axis_tready stays high; once the two-entry output
// buffer fills, m_axis_tready low stalls the reads. The capacity register
// sits at byte address 0 (reset 1024, zero acts as one, values above DEPTH
// act as DEPTH). The store needs no clearing pass after reset.
module drop_oldest_queue_burst_drain #(
    parameter int DEPTH     = 1024,
    parameter int MAX_DRAIN = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] value, [38:32] drain_count, [39] zero
    input  logic [doqbd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] req_type
    input  logic                               s_axis_tuser,
    // stream out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] value_out
    output logic [doqbd_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [doqbd_pkg::APB_AW-1:0]       paddr,
    input  logic [doqbd_pkg::APB_DW-1:0]       pwdata,
    output logic [doqbd_pkg::APB_DW-1:0]       prdata,
    output logic                               pready
);
    import doqbd_pkg::*;

    logic [CAP_W-1:0]        r_capacity;
    logic                    reg_sel;
    logic signed [VAL_W-1:0] in_value;
    logic [DCNT_W-1:0]       in_count;
    logic signed [VAL_W-1:0] out_value;
    t_cmd                    cmd;
    t_stat                   stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1:2] == REG_CAPACITY);
    assign prdata  = reg_sel ? {{(APB_DW - CAP_W){1'b0}}, r_capacity} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign in_value     = s_axis_tdata[VAL_W-1:0];
    assign in_count     = s_axis_tdata[VAL_W +: DCNT_W];
    assign m_axis_tdata = out_value;

    doqbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    doqbd_dp #(
        .DEPTH     (DEPTH),
        .MAX_DRAIN (MAX_DRAIN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_capacity    (r_capacity),
        .i_req_type    (s_axis_tuser),
        .i_value       (in_value),
        .i_drain_count (in_count),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .o_m_value     (out_value),
        .o_m_last      (m_axis_tlast)
    );

endmodule

// ----- sim/tb_drop_oldest_queue_burst_drain.sv -----
// ----------------------------------------------------------------------------
// tb_drop_oldest_queue_burst_drain
// Self-checking bench for the drop-oldest queue: a ring model predicts every
// drained value and its tlast from the accepted request beats, and the output
// stream is compared against it. Directed corner cases come first, then a
// fill at a capacity above the ring depth, then random phases at several
// capacities with idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
module tb_drop_oldest_queue_burst_drain;
    timeunit 1ns;
    timeprecision 1ps;

    import doqbd_pkg::*;

    localparam int RING_DEPTH = 1024;
    localparam int MAX_BURST  = 64;
    localparam int SETTLE     = 16;
    localparam longint LIMIT_NS = 2_000_000;

    // register map; the second address has no register behind it
    localparam logic [APB_AW-1:0] ADDR_CAPACITY = APB_AW'({REG_CAPACITY, 2'b00});
    localparam logic [APB_AW-1:0] ADDR_SPARE    = APB_AW'(4);

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_drained;

    class drop_queue_scoreboard;
        logic [VAL_W-1:0] ring [RING_DEPTH];
        int unsigned      head;
        int unsigned      tail;
        int unsigned      held;
        logic [CAP_W-1:0] capacity;
        t_drained         expected_drains [$];
        int               errors;

        function new();
            head     = 0;
            tail     = 0;
            held     = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function int unsigned cap_limit();
            if (capacity == 0)
                return 1;
            if (capacity > RING_DEPTH)
                return RING_DEPTH;
            return capacity;
        endfunction

        function void write_reg(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
            if (addr == ADDR_CAPACITY)
                capacity = data[CAP_W-1:0];
        endfunction

        function void note_request(logic kind, logic [VAL_W-1:0] value,
                                   logic [DCNT_W-1:0] count);
            int unsigned want;
            int unsigned n;
            t_drained    beat;
            if (kind == REQ_ENQ) begin
                if (held >= cap_limit() && held > 0) begin
                    head = (head + 1) % RING_DEPTH;
                    held--;
                end
                ring[tail] = value;
                tail = (tail + 1) % RING_DEPTH;
                held++;
            end else begin
                want = (count > MAX_BURST) ? MAX_BURST : count;
                n    = (want < held) ? want : held;
                for (int i = 0; i < n; i++) begin
                    beat.value = ring[head];
                    beat.last  = (i == n - 1);
                    expected_drains.insert(expected_drains.size(), beat);
                    head = (head + 1) % RING_DEPTH;
                    held--;
                end
            end
        endfunction

        function void check_drained(logic [VAL_W-1:0] got_value, logic got_last);
            t_drained want;
            if (expected_drains.size() == 0) begin
                $error("unexpected beat: value_out %h last %b", got_value, got_last);
                errors++;
            end else begin
                want = expected_drains.pop_front();
                if (got_value !== want.value) begin
                    $error("value_out: expected %h, actual %h", want.value, got_value);
                    errors++;
                end
                if (got_last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, got_last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] value, [38:32] drain_count, [39] zero
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    // [0] req_type
    logic                   s_axis_tuser  = REQ_ENQ;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] value_out
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_AW-1:0]      paddr         = '0;
    logic [APB_DW-1:0]      pwdata        = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    drop_queue_scoreboard sb;

    drop_oldest_queue_burst_drain #(
        .DEPTH     (RING_DEPTH),
        .MAX_DRAIN (MAX_BURST)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tuser, s_axis_tdata[VAL_W-1:0],
                            s_axis_tdata[VAL_W +: DCNT_W]);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_drained(m_axis_tdata, m_axis_tlast);
    end

    task automatic send_beat(input logic kind, input logic [VAL_W-1:0] value,
                             input logic [DCNT_W-1:0] count);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= S_TDATA_W'({count, value});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid, then wait out every expected beat plus the block's latency
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_drains.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write, then a read back of the capacity register
    task automatic reg_access(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(addr, data);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CAPACITY;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(sb.capacity)) begin
            $error("capacity: expected %h, actual %h", APB_DW'(sb.capacity), prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [DCNT_W-1:0] pick_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DCNT_W'($urandom_range(MAX_BURST + 1, 127));
            2:       return DCNT_W'(MAX_BURST);
            default: return DCNT_W'($urandom_range(1, 20));
        endcase
    endfunction

    task automatic run_phase(input int n_items, input int drain_pct,
                             input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) begin
            if ($urandom_range(99) < drain_pct)
                send_beat(REQ_DRAIN, $urandom(), pick_count());
            else
                send_beat(REQ_ENQ, pick_value(), DCNT_W'($urandom()));
        end
        finish_phase();
    endtask

    initial begin
        #(LIMIT_NS);
        $display("FAIL drop_oldest_queue_burst_drain");
        $finish;
    end

    initial begin
        int caps [7];
        int idles [4];
        int stalls [4];
        caps   = '{5, 1, 37, 1024, 2, 16, 2047};
        idles  = '{0, 48, 0, 38};
        stalls = '{0, 0, 48, 38};
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, value extremes, zero count, count above the burst limit
        send_beat(REQ_DRAIN, 32'h0, 7'd5);
        send_beat(REQ_ENQ, 32'h8000_0000, '0);
        send_beat(REQ_ENQ, 32'h7FFF_FFFF, '0);
        send_beat(REQ_ENQ, 32'h0000_0000, '0);
        send_beat(REQ_ENQ, 32'hFFFF_FFFF, '1);
        send_beat(REQ_DRAIN, 32'h0, 7'd0);
        send_beat(REQ_DRAIN, 32'h0, 7'd1);
        send_beat(REQ_DRAIN, 32'hFFFF_FFFF, 7'd127);
        finish_phase();

        // zero capacity keeps one value
        reg_access(ADDR_CAPACITY, 32'd0);
        repeat (3) send_beat(REQ_ENQ, $urandom(), '0);
        send_beat(REQ_DRAIN, 32'h0, 7'd2);
        finish_phase();

        // fill to capacity 8, then lower capacity below occupancy: each enqueue drops one, nothing grows
        reg_access(ADDR_CAPACITY, 32'd8);
        repeat (8) send_beat(REQ_ENQ, $urandom(), '0);
        finish_phase();
        reg_access(ADDR_CAPACITY, 32'hFFFF_F803);
        repeat (2) send_beat(REQ_ENQ, $urandom(), '0);
        send_beat(REQ_DRAIN, 32'h0, DCNT_W'(MAX_BURST));
        finish_phase();
        reg_access(ADDR_SPARE, 32'h0000_0001);

        // capacity above depth, fill past one full burst then drain it out
        reg_access(ADDR_CAPACITY, 32'd2047);
        recv_stall_pct = 48;
        repeat (70) send_beat(REQ_ENQ, pick_value(), DCNT_W'($urandom()));
        send_beat(REQ_DRAIN, 32'h0, 7'd127);
        send_beat(REQ_DRAIN, 32'h0, DCNT_W'(MAX_BURST));
        send_beat(REQ_DRAIN, 32'h0, DCNT_W'(MAX_BURST + 1));
        finish_phase();

        for (int i = 0; i < 7; i++) begin
            reg_access(ADDR_CAPACITY, APB_DW'(caps[i]));
            run_phase(36, 35, idles[i % 4], stalls[i % 4]);
        end

        if (sb.errors == 0)
            $display("PASS drop_oldest_queue_burst_drain");
        else
            $display("FAIL drop_oldest_queue_burst_drain");
        $finish;
    end

endmodule
